[src/crl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crl_pkg
// Shared constants for the closed Catmull-Rom loop evaluator.
// ----------------------------------------------------------------------------
package crl_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int OUT_WIDTH   = 32;
  localparam int CFG_WIDTH   = 5;
  localparam int MIN_POINTS  = 4;
  localparam int FIFO_DEPTH  = 16;
  localparam int FIFO_AW     = 4;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

endpackage

[src/crl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crl_ram
// Generic RAM: one write port, two registered read ports (read before write).
// ----------------------------------------------------------------------------
module crl_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[src/crl_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crl_lane
// Six-stage pipeline evaluating position and derivative for one coordinate.
// ----------------------------------------------------------------------------
module crl_lane import crl_pkg::*; #(
  parameter int CW = 32
) (
  input  logic                        clk,
  input  logic signed [CW-1:0]        p0,
  input  logic signed [CW-1:0]        p1,
  input  logic signed [CW-1:0]        p2,
  input  logic signed [CW-1:0]        p3,
  input  logic [FRAC_BITS-1:0]        u_in,
  output logic signed [OUT_WIDTH-1:0] pos,
  output logic signed [OUT_WIDTH-1:0] deriv
);

  localparam int WA = CW + 8;
  localparam int WM = WA + FRAC_BITS + 1;
  localparam int WE = (WA > OUT_WIDTH) ? WA : OUT_WIDTH + 1;
  localparam logic signed [WM-1:0] HALF = WM'(1) <<< (FRAC_BITS - 1);

  // Stage C: doubled coefficients.
  logic signed [WA-1:0] a0_c, a1_c, a2_c, a3_c;
  logic [FRAC_BITS-1:0] u_c;
  // Stage D: first product.
  logic signed [WM-1:0] m1_d;
  logic signed [WA-1:0] a1_d, a2_d, a3_d;
  logic [FRAC_BITS-1:0] u_d;
  // Stage E.
  logic signed [WA-1:0] h1_e, g1_e, a2_e, a3_e;
  logic [FRAC_BITS-1:0] u_e;
  // Stage F.
  logic signed [WM-1:0] mh_f, mg_f;
  logic signed [WA-1:0] a2_f, a3_f;
  logic [FRAC_BITS-1:0] u_f;
  // Stage G.
  logic signed [WA-1:0] h2_g, gf_g, a3_g;
  logic [FRAC_BITS-1:0] u_g;
  // Stage H.
  logic signed [WM-1:0] mh_h;
  logic signed [WA-1:0] gf_h, a3_h;

  logic signed [WA-1:0] e0, e1, e2, e3;
  logic signed [WM+1:0] m3_d;
  logic signed [WM-1:0] r1, rh, rg, rh2;
  logic signed [WM+1:0] r3;
  logic signed [WA-1:0] h_fin;
  logic signed [WE-1:0] pos_w, der_w;

  assign e0 = WA'(p0);
  assign e1 = WA'(p1);
  assign e2 = WA'(p2);
  assign e3 = WA'(p3);

  assign m3_d = (WM+2)'(m1_d) + ((WM+2)'(m1_d) <<< 1);
  assign r1   = (m1_d + HALF) >>> FRAC_BITS;
  assign r3   = (m3_d + (WM+2)'(HALF)) >>> FRAC_BITS;
  assign rh   = (mh_f + HALF) >>> FRAC_BITS;
  assign rg   = (mg_f + HALF) >>> FRAC_BITS;
  assign rh2  = (mh_h + HALF) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    a0_c <= -e0 + 3 * e1 - 3 * e2 + e3;
    a1_c <= 2 * e0 - 5 * e1 + 4 * e2 - e3;
    a2_c <= e2 - e0;
    a3_c <= 2 * e1;
    u_c  <= u_in;

    m1_d <= WM'(a0_c) * $signed({1'b0, u_c});
    a1_d <= a1_c;
    a2_d <= a2_c;
    a3_d <= a3_c;
    u_d  <= u_c;

    h1_e <= WA'(r1) + a1_d;
    g1_e <= WA'(r3) + (a1_d <<< 1);
    a2_e <= a2_d;
    a3_e <= a3_d;
    u_e  <= u_d;

    mh_f <= WM'(h1_e) * $signed({1'b0, u_e});
    mg_f <= WM'(g1_e) * $signed({1'b0, u_e});
    a2_f <= a2_e;
    a3_f <= a3_e;
    u_f  <= u_e;

    h2_g <= WA'(rh) + a2_f;
    gf_g <= WA'(rg) + a2_f;
    a3_g <= a3_f;
    u_g  <= u_f;

    mh_h <= WM'(h2_g) * $signed({1'b0, u_g});
    gf_h <= gf_g;
    a3_h <= a3_g;
  end

  // The halving rounds half up, then the result is clamped to the output range.
  assign h_fin = WA'(rh2) + a3_h;
  assign pos_w = WE'((h_fin + WA'(1)) >>> 1);
  assign der_w = WE'((gf_h + WA'(1)) >>> 1);

  function automatic logic signed [OUT_WIDTH-1:0] sat(input logic signed [WE-1:0] v);
    logic signed [WE-1:0] hi;
    logic signed [WE-1:0] lo;
    hi = WE'({1'b0, {(OUT_WIDTH-1){1'b1}}});
    lo = -hi - WE'(1);
    if (v > hi) begin
      sat = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    end else if (v < lo) begin
      sat = {1'b1, {(OUT_WIDTH-1){1'b0}}};
    end else begin
      sat = OUT_WIDTH'(v);
    end
  endfunction

  assign pos   = sat(pos_w);
  assign deriv = sat(der_w);

endmodule

[src/catmull_rom_loop_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_loop_eval
// Closed uniform Catmull-Rom loop: stores control points, evaluates position
// and first derivative at a global parameter.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle, writes and evaluations alike, while
// in_ready is high. An evaluation's result waits in a 16-entry output buffer;
// the input stalls only once 16 evaluations are in flight or buffered. The
// control points sit in two copies of a dual-read RAM, so the four neighbors
// of a segment are fetched in the same cycle. A point write lands at its
// transfer, and an evaluation reads the RAM in the cycle after its own
// transfer, so each evaluation sees exactly the writes that came before it.
// Points must be written before they are used.
module catmull_rom_loop_eval import crl_pkg::*; #(
  parameter int MAX_POINTS  = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [CFG_WIDTH-1:0]        cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic [3:0]                  point_index,
  input  logic signed [31:0]          coord_x,
  input  logic signed [31:0]          coord_y,
  input  logic signed [31:0]          coord_z,
  input  logic [23:0]                 global_t,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OUT_WIDTH-1:0] pos_x,
  output logic signed [OUT_WIDTH-1:0] pos_y,
  output logic signed [OUT_WIDTH-1:0] pos_z,
  output logic signed [OUT_WIDTH-1:0] deriv_x,
  output logic signed [OUT_WIDTH-1:0] deriv_y,
  output logic signed [OUT_WIDTH-1:0] deriv_z
);

  localparam int CW    = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int NW    = $clog2(MAX_POINTS + 1);
  localparam int IW    = NW + 1;
  localparam int PW    = FRAC_BITS + NW;
  localparam int RW    = 3 * CW;
  localparam int DEPTH = 8;
  localparam int OW    = 6 * OUT_WIDTH;

  logic [CFG_WIDTH-1:0] num_points;
  logic                 in_xfer, out_xfer, eval_xfer;
  logic [NW-1:0]        n_sel;
  logic [PW-1:0]        prod;

  logic [AW-1:0]        seg_a;
  logic [NW-1:0]        n_a;
  logic [FRAC_BITS-1:0] u_a, u_b;
  logic [DEPTH-1:0]     vld;

  logic [IW-1:0]        s0, s1, s2, nn, i0, i2, i3;
  logic [RW-1:0]        rd0, rd1, rd2, rd3, wdata;
  logic                 we;

  logic [OUT_WIDTH-1:0] px, py, pz, dx, dy, dz;

  logic [OW-1:0]        fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_AW:0]     fifo_count, occ;
  logic [OW-1:0]        head;

  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign eval_xfer = in_xfer && (req_type == REQ_EVAL);
  assign in_ready  = occ < (FIFO_AW+1)'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= CFG_WIDTH'(MIN_POINTS);
    end else if (cfg_wr_en) begin
      num_points <= cfg_wr_data;
    end
  end

  // Point count clamped to the supported range.
  always_comb begin
    if (32'(num_points) < MIN_POINTS) begin
      n_sel = NW'(MIN_POINTS);
    end else if (32'(num_points) > MAX_POINTS) begin
      n_sel = NW'(MAX_POINTS);
    end else begin
      n_sel = NW'(num_points);
    end
  end

  // The integer part of global_t only adds whole turns, so the segment is the
  // integer part of frac * n, which is always below n.
  assign prod = PW'(global_t[FRAC_BITS-1:0]) * PW'(n_sel);

  always_ff @(posedge clk) begin
    seg_a <= AW'(prod[PW-1:FRAC_BITS]);
    u_a   <= prod[FRAC_BITS-1:0];
    n_a   <= n_sel;
    u_b   <= u_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DEPTH-2:0], eval_xfer};
    end
  end

  assign nn = IW'(n_a);
  assign s0 = IW'(seg_a);
  assign s1 = s0 + IW'(1);
  assign s2 = s0 + IW'(2);
  assign i0 = (s0 == '0) ? nn - IW'(1) : s0 - IW'(1);
  assign i2 = (s1 == nn) ? '0 : s1;
  assign i3 = (s2 >= nn) ? s2 - nn : s2;

  assign we    = in_xfer && (req_type == REQ_WRITE) && (32'(point_index) < MAX_POINTS);
  assign wdata = {CW'(coord_z), CW'(coord_y), CW'(coord_x)};

  crl_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_ram_lo (
    .clk     (clk),
    .we      (we),
    .waddr   (AW'(point_index)),
    .wdata   (wdata),
    .raddr_a (i0[AW-1:0]),
    .raddr_b (seg_a),
    .rdata_a (rd0),
    .rdata_b (rd1)
  );

  crl_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_ram_hi (
    .clk     (clk),
    .we      (we),
    .waddr   (AW'(point_index)),
    .wdata   (wdata),
    .raddr_a (i2[AW-1:0]),
    .raddr_b (i3[AW-1:0]),
    .rdata_a (rd2),
    .rdata_b (rd3)
  );

  crl_lane #(.CW(CW)) u_lane_x (
    .clk(clk), .p0(rd0[CW-1:0]), .p1(rd1[CW-1:0]), .p2(rd2[CW-1:0]),
    .p3(rd3[CW-1:0]), .u_in(u_b), .pos(px), .deriv(dx)
  );

  crl_lane #(.CW(CW)) u_lane_y (
    .clk(clk), .p0(rd0[2*CW-1:CW]), .p1(rd1[2*CW-1:CW]), .p2(rd2[2*CW-1:CW]),
    .p3(rd3[2*CW-1:CW]), .u_in(u_b), .pos(py), .deriv(dy)
  );

  crl_lane #(.CW(CW)) u_lane_z (
    .clk(clk), .p0(rd0[3*CW-1:2*CW]), .p1(rd1[3*CW-1:2*CW]),
    .p2(rd2[3*CW-1:2*CW]), .p3(rd3[3*CW-1:2*CW]), .u_in(u_b), .pos(pz),
    .deriv(dz)
  );

  // Output buffer; occ counts evaluations from transfer in until transfer out.
  always_ff @(posedge clk) begin
    if (vld[DEPTH-1]) begin
      fifo[wr_ptr] <= {dz, dy, dx, pz, py, px};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
      occ        <= '0;
    end else begin
      if (vld[DEPTH-1]) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_count <= fifo_count + (FIFO_AW+1)'(vld[DEPTH-1]) - (FIFO_AW+1)'(out_xfer);
      occ        <= occ + (FIFO_AW+1)'(eval_xfer) - (FIFO_AW+1)'(out_xfer);
    end
  end

  assign out_valid = fifo_count != '0;
  assign head      = fifo[rd_ptr];
  assign pos_x     = head[OUT_WIDTH-1:0];
  assign pos_y     = head[2*OUT_WIDTH-1:OUT_WIDTH];
  assign pos_z     = head[3*OUT_WIDTH-1:2*OUT_WIDTH];
  assign deriv_x   = head[4*OUT_WIDTH-1:3*OUT_WIDTH];
  assign deriv_y   = head[5*OUT_WIDTH-1:4*OUT_WIDTH];
  assign deriv_z   = head[6*OUT_WIDTH-1:5*OUT_WIDTH];

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the closed Catmull-Rom loop evaluator. A queue of
// point writes and curve evaluations feeds a valid/ready driver. A clocked
// model of the curve math predicts each evaluation result when its transfer
// happens. A monitor compares every output transfer with the oldest
// prediction. The point count is changed between phases while the block is
// idle.
// ----------------------------------------------------------------------------
module tb_top;
  import crl_pkg::*;

  localparam int NPTS  = 16;
  localparam int LIMIT = 400000;
  localparam int DRAIN = 16;

  typedef struct packed {
    logic              kind;
    logic [3:0]        slot;
    logic signed [31:0] x, y, z;
    logic [23:0]       gt;
  } req_t;

  typedef struct packed {
    logic signed [31:0] px, py, pz, dx, dy, dz;
  } curve_pt_t;

  logic clk, rst;
  logic cfg_wr_en;
  logic [CFG_WIDTH-1:0] cfg_wr_data;
  logic in_valid, in_ready, req_type;
  logic [3:0] point_index;
  logic signed [31:0] coord_x, coord_y, coord_z;
  logic [23:0] global_t;
  logic out_valid, out_ready;
  logic signed [OUT_WIDTH-1:0] pos_x, pos_y, pos_z, deriv_x, deriv_y, deriv_z;

  req_t      pending[$];
  curve_pt_t expected[$];
  longint    ctrl_pts[NPTS][3];
  int        loop_len;
  int        errors;
  int        cycles;
  int        send_gap;
  int        recv_gap;
  int        hold_left;
  logic      hold_go, hold_done;
  logic      in_taken;

  catmull_rom_loop_eval DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .point_index(point_index),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .global_t(global_t),
    .out_valid(out_valid), .out_ready(out_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .deriv_x(deriv_x), .deriv_y(deriv_y), .deriv_z(deriv_z)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  function automatic longint round_q16(input longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic logic [31:0] halve_sat(input longint dbl);
    longint v;
    v = (dbl + 1) >>> 1;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // One axis of the spline; coefficients are kept doubled so they stay integers.
  function automatic void eval_axis(input longint p0, p1, p2, p3, input longint u,
                                    output logic [31:0] pos, output logic [31:0] der);
    longint a0, a1, a2, a3, h, g;
    a0 = -p0 + 3 * p1 - 3 * p2 + p3;
    a1 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    a2 = -p0 + p2;
    a3 = 2 * p1;
    h = round_q16(a0 * u) + a1;
    h = round_q16(h * u) + a2;
    h = round_q16(h * u) + a3;
    g = round_q16(3 * a0 * u) + 2 * a1;
    g = round_q16(g * u) + a2;
    pos = halve_sat(h);
    der = halve_sat(g);
  endfunction

  function automatic curve_pt_t predict_curve(input logic [23:0] gt);
    curve_pt_t r;
    longint n, s, seg, u;
    int i0, i1, i2, i3;
    logic [31:0] p[3], d[3];
    n = loop_len < MIN_POINTS ? MIN_POINTS : (loop_len > NPTS ? NPTS : loop_len);
    s = longint'(gt) * n;
    seg = (s >> 16) % n;
    u = s & 64'hFFFF;
    i0 = int'((seg + n - 1) % n);
    i1 = int'(seg);
    i2 = int'((seg + 1) % n);
    i3 = int'((seg + 2) % n);
    for (int c = 0; c < 3; c++)
      eval_axis(ctrl_pts[i0][c], ctrl_pts[i1][c], ctrl_pts[i2][c], ctrl_pts[i3][c],
                u, p[c], d[c]);
    r.px = p[0]; r.py = p[1]; r.pz = p[2];
    r.dx = d[0]; r.dy = d[1]; r.dz = d[2];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4: return $urandom_range(32'h0003_0000) - 32'h0001_8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] rand_param();
    case ($urandom_range(7))
      0: return 24'h0;
      1: return 24'hFF_FFFF;
      2: return {8'($urandom), 16'h0};
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic req_t make_write(input logic [3:0] slot,
                                      input logic [31:0] x, y, z);
    req_t r;
    r.kind = REQ_WRITE; r.slot = slot; r.x = x; r.y = y; r.z = z;
    r.gt = 24'($urandom);
    return r;
  endfunction

  function automatic req_t make_eval(input logic [23:0] gt);
    req_t r;
    r.kind = REQ_EVAL; r.slot = 4'($urandom);
    r.x = $urandom; r.y = $urandom; r.z = $urandom;
    r.gt = gt;
    return r;
  endfunction

  // Records whether the input item was taken at the last rising edge.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
    end
  end

  // Driver: payload and valid change only at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_taken) begin
      // The transfer (if any) happened at the last rising edge.
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending.size() > 0) begin
        req_t r;
        r = pending.pop_front();
        in_valid    <= 1'b1;
        req_type    <= r.kind;
        point_index <= r.slot;
        coord_x     <= r.x;
        coord_y     <= r.y;
        coord_z     <= r.z;
        global_t    <= r.gt;
        send_gap    <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold so the block backs up.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap  <= recv_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      recv_gap  <= pick_gap();
    end
  end

  // Predictor and monitor: everything sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
      if (cfg_wr_en) loop_len = cfg_wr_data;
      if (in_valid && in_ready) begin
        if (req_type == REQ_WRITE) begin
          ctrl_pts[point_index][0] = longint'(coord_x);
          ctrl_pts[point_index][1] = longint'(coord_y);
          ctrl_pts[point_index][2] = longint'(coord_z);
        end else begin
          expected.push_back(predict_curve(global_t));
        end
      end
      if (out_valid && out_ready) begin
        if (expected.size() == 0) begin
          $display("MISMATCH: result transfer with nothing expected");
          errors++;
        end else begin
          curve_pt_t e;
          e = expected.pop_front();
          if (pos_x !== e.px) report("pos_x", pos_x, e.px);
          if (pos_y !== e.py) report("pos_y", pos_y, e.py);
          if (pos_z !== e.pz) report("pos_z", pos_z, e.pz);
          if (deriv_x !== e.dx) report("deriv_x", deriv_x, e.dx);
          if (deriv_y !== e.dy) report("deriv_y", deriv_y, e.dy);
          if (deriv_z !== e.dz) report("deriv_z", deriv_z, e.dz);
        end
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pending.size() > 0 || in_valid || expected.size() > 0);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic set_loop_len(input logic [CFG_WIDTH-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 30)
        pending.push_back(make_write(4'($urandom), rand_coord(), rand_coord(),
                                     rand_coord()));
      else
        pending.push_back(make_eval(rand_param()));
    end
  endtask

  initial begin
    logic [CFG_WIDTH-1:0] lens[6];
    errors = 0;
    cycles = 0;
    loop_len = MIN_POINTS;
    hold_go = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    req_type = REQ_WRITE;
    point_index = '0;
    coord_x = '0; coord_y = '0; coord_z = '0;
    global_t = '0;
    rst = 1'b1;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every slot is written before any evaluation, with alternating extremes
    // so that neighboring segments overflow and saturate.
    set_loop_len(5'd4);
    for (int i = 0; i < NPTS; i++)
      pending.push_back(make_write(4'(i),
        i[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
        i[1] ? 32'h8000_0000 : 32'h7FFF_FFFF,
        (i * 32'h0001_0000) - 32'h0008_0000));
    pending.push_back(make_eval(24'h00_0000));
    pending.push_back(make_eval(24'hFF_FFFF));
    pending.push_back(make_eval(24'h00_8000));
    pending.push_back(make_eval(24'h00_FFFF));
    pending.push_back(make_eval(24'h01_0000));
    pending.push_back(make_write(4'd1, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000));
    pending.push_back(make_eval(24'h00_4000));
    wait_idle();

    // Point count settings: extremes, values that clamp, and random ones.
    lens[0] = 5'd16;
    lens[1] = 5'd0;
    lens[2] = 5'd31;
    lens[3] = 5'd3;
    lens[4] = 5'($urandom_range(16, 4));
    lens[5] = 5'($urandom_range(16, 4));
    for (int ph = 0; ph < 6; ph++) begin
      set_loop_len(lens[ph]);
      if (ph == 1) hold_go = 1'b1;
      queue_random(115);
      wait_idle();
    end

    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
src/crl_pkg.sv
src/crl_ram.sv
src/crl_lane.sv
src/catmull_rom_loop_eval.sv
tb/tb_top.sv
